FILE: design/sioc_pkg.sv
`default_nettype none
package sioc_pkg;

  localparam int unsigned BANK_COUNT_DEF = 16;
  localparam int unsigned GLOBAL_REGS    = 48;
  localparam int unsigned BANK_REGS      = 208;

  localparam logic [7:0] KEY_ENTER   = 8'h87;
  localparam logic [7:0] KEY_EXIT    = 8'haa;
  localparam logic [7:0] BANK_BASE   = 8'h30;
  localparam logic [7:0] LOCK_REG    = 8'h26;
  localparam int unsigned LOCK_BIT   = 5;
  localparam logic [7:0] DEV_SEL_REG = 8'h07;
  localparam logic [7:0] IDLE_READ   = 8'hff;

  localparam int unsigned GAW = $clog2(GLOBAL_REGS);

  typedef enum logic [1:0] {
    MODE_IDLE,
    MODE_KEY,
    MODE_CONFIG
  } mode_e;

  typedef enum logic [1:0] {
    SRC_IMM,
    SRC_GLOB,
    SRC_BANK
  } src_e;

  typedef struct packed {
    logic           glob_we;
    logic           glob_re;
    logic [GAW-1:0] glob_addr;
    logic           bank_we;
    logic           bank_re;
    logic [7:0]     bank_dev;
    logic [7:0]     bank_offs;
    logic [7:0]     wdata;
  } mem_req_t;

  typedef struct packed {
    src_e       src;
    logic [7:0] imm;
    logic       glob_valid;
    logic       mode;
  } stage_t;

  typedef struct packed {
    logic       busy;
    logic [7:0] bank;
    logic [7:0] offs;
    logic [7:0] wdata;
  } init_t;

  function automatic logic [7:0] glob_reset(input logic [GAW-1:0] idx);
    logic [7:0] val;
    unique case (idx)
      6'h20:   val = 8'h97;
      6'h21:   val = 8'h71;
      6'h22:   val = 8'hff;
      6'h24:   val = 8'ha4;
      default: val = 8'h00;
    endcase
    return val;
  endfunction

  function automatic logic [7:0] bank_reset(input logic [7:0] bank, input logic [7:0] offs);
    logic [7:0] val;
    unique case ({bank, offs})
      16'h0000: val = 8'h01;  16'h0001: val = 8'h02;  16'h0030: val = 8'h03;
      16'h0031: val = 8'hf0;  16'h0040: val = 8'h06;  16'h0041: val = 8'h02;
      16'h0044: val = 8'h02;  16'h00c0: val = 8'h0e;
      16'h0100: val = 8'h01;  16'h0101: val = 8'h02;  16'h0130: val = 8'h03;
      16'h0131: val = 8'h78;  16'h0140: val = 8'h07;  16'h0141: val = 8'h01;
      16'h0144: val = 8'h04;  16'h01c0: val = 8'h3c;
      16'h0200: val = 8'h01;  16'h0201: val = 8'h02;  16'h0230: val = 8'h03;
      16'h0231: val = 8'hf8;  16'h0240: val = 8'h04;  16'h0241: val = 8'h02;
      16'h0300: val = 8'h01;  16'h0301: val = 8'h02;  16'h0330: val = 8'h02;
      16'h0331: val = 8'hf8;  16'h0340: val = 8'h03;  16'h0341: val = 8'h02;
      16'h0400: val = 8'h01;  16'h0401: val = 8'h02;  16'h0430: val = 8'h00;
      16'h0431: val = 8'h70;  16'h0440: val = 8'h08;  16'h0441: val = 8'h02;
      16'h0500: val = 8'h01;  16'h0501: val = 8'h02;  16'h0530: val = 8'h00;
      16'h0531: val = 8'h60;  16'h0532: val = 8'h00;  16'h0533: val = 8'h64;
      16'h0540: val = 8'h01;  16'h0541: val = 8'h02;  16'h0542: val = 8'h0c;
      16'h0543: val = 8'h02;  16'h05c0: val = 8'h40;
      16'h0601: val = 8'h02;  16'h0641: val = 8'h02;  16'h0644: val = 8'h04;
      16'h0645: val = 8'h04;
      16'h0701: val = 8'h02;  16'h0741: val = 8'h02;  16'h0743: val = 8'h02;
      16'h07b0: val = 8'h01;  16'h07b1: val = 8'h01;  16'h07b2: val = 8'h01;
      16'h07b3: val = 8'h01;  16'h07b4: val = 8'h01;  16'h07b5: val = 8'h01;
      16'h07b6: val = 8'h01;
      16'h0801: val = 8'h02;  16'h0841: val = 8'h02;  16'h0843: val = 8'h02;
      16'h08b8: val = 8'h01;  16'h08b9: val = 8'h01;  16'h08ba: val = 8'h01;
      16'h08bb: val = 8'h01;  16'h08bc: val = 8'h01;  16'h08bd: val = 8'h01;
      16'h08be: val = 8'h01;  16'h08bf: val = 8'h01;
      default:  val = 8'h00;
    endcase
    return val;
  endfunction

endpackage
`default_nettype wire

FILE: design/sioc_ram.sv
`default_nettype none
module sioc_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 48
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule
`default_nettype wire

FILE: design/sioc_init.sv
`default_nettype none
module sioc_init #(
  parameter int unsigned BANK_COUNT = sioc_pkg::BANK_COUNT_DEF
) (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  output sioc_pkg::init_t      init_o
);

  localparam int unsigned BW = $clog2(BANK_COUNT);
  localparam logic [BW-1:0] LAST_BANK = BW'(BANK_COUNT - 1);
  localparam logic [7:0] LAST_OFFS = 8'(sioc_pkg::BANK_REGS - 1);

  logic          busy_q, busy_d;
  logic [BW-1:0] bank_q, bank_d;
  logic [7:0]    offs_q, offs_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b1;
      bank_q <= '0;
      offs_q <= '0;
    end else begin
      busy_q <= busy_d;
      bank_q <= bank_d;
      offs_q <= offs_d;
    end
  end

  always_comb begin
    busy_d = busy_q;
    bank_d = bank_q;
    offs_d = offs_q;
    if (busy_q) begin
      if (offs_q == LAST_OFFS) begin
        offs_d = '0;
        if (bank_q == LAST_BANK) begin
          busy_d = 1'b0;
        end else begin
          bank_d = bank_q + 1'b1;
        end
      end else begin
        offs_d = offs_q + 1'b1;
      end
    end
  end

  assign init_o.busy  = busy_q;
  assign init_o.bank  = 8'(bank_q);
  assign init_o.offs  = offs_q;
  assign init_o.wdata = sioc_pkg::bank_reset(8'(bank_q), offs_q);

endmodule
`default_nettype wire

FILE: design/sioc_decode.sv
`default_nettype none
module sioc_decode #(
  parameter int unsigned BANK_COUNT = sioc_pkg::BANK_COUNT_DEF
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        accept_i,
  input  wire logic        op_i,
  input  wire logic        data_port_i,
  input  wire logic [7:0]  write_data_i,
  output sioc_pkg::mem_req_t req_o,
  output sioc_pkg::stage_t   stage_o
);

  sioc_pkg::mode_e                    mode_q, mode_d;
  logic [7:0]                         index_q, index_d;
  logic [7:0]                         dev_q, dev_d;
  logic                               blocked_q, blocked_d;
  logic [sioc_pkg::GLOBAL_REGS-1:0]   gvalid_q, gvalid_d;

  logic                      is_glob;
  logic [sioc_pkg::GAW-1:0]  gidx;
  logic                      dev_ok;
  logic                      in_cfg;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q    <= sioc_pkg::MODE_IDLE;
      index_q   <= '0;
      dev_q     <= '0;
      blocked_q <= 1'b0;
      gvalid_q  <= '0;
    end else begin
      mode_q    <= mode_d;
      index_q   <= index_d;
      dev_q     <= dev_d;
      blocked_q <= blocked_d;
      gvalid_q  <= gvalid_d;
    end
  end

  assign is_glob = index_q < sioc_pkg::BANK_BASE;
  assign gidx    = index_q[sioc_pkg::GAW-1:0];
  assign dev_ok  = {1'b0, dev_q} < 9'(BANK_COUNT);
  assign in_cfg  = mode_q == sioc_pkg::MODE_CONFIG;

  always_comb begin
    mode_d    = mode_q;
    index_d   = index_q;
    dev_d     = dev_q;
    blocked_d = blocked_q;
    gvalid_d  = gvalid_q;

    req_o.glob_we   = 1'b0;
    req_o.glob_re   = 1'b0;
    req_o.glob_addr = gidx;
    req_o.bank_we   = 1'b0;
    req_o.bank_re   = 1'b0;
    req_o.bank_dev  = dev_q;
    req_o.bank_offs = index_q - sioc_pkg::BANK_BASE;
    req_o.wdata     = write_data_i;

    stage_o.src        = sioc_pkg::SRC_IMM;
    stage_o.imm        = 8'h00;
    stage_o.glob_valid = 1'b0;

    if (accept_i) begin
      if (op_i) begin
        if (!data_port_i) begin
          if (!in_cfg) begin
            if (write_data_i == sioc_pkg::KEY_ENTER) begin
              mode_d = (mode_q == sioc_pkg::MODE_KEY) ? sioc_pkg::MODE_CONFIG
                                                      : sioc_pkg::MODE_KEY;
            end else begin
              mode_d = sioc_pkg::MODE_IDLE;
            end
          end else if (write_data_i == sioc_pkg::KEY_EXIT) begin
            mode_d = sioc_pkg::MODE_IDLE;
          end else begin
            index_d = write_data_i;
          end
        end else if (in_cfg && !blocked_q) begin
          if (is_glob) begin
            req_o.glob_we  = 1'b1;
            gvalid_d[gidx] = 1'b1;
            if (index_q == sioc_pkg::DEV_SEL_REG) begin
              dev_d = write_data_i;
            end
            if (index_q == sioc_pkg::LOCK_REG) begin
              blocked_d = write_data_i[sioc_pkg::LOCK_BIT];
            end
          end else if (dev_ok) begin
            req_o.bank_we = 1'b1;
          end
        end
      end else begin
        stage_o.imm = sioc_pkg::IDLE_READ;
        if (in_cfg) begin
          if (!data_port_i) begin
            stage_o.imm = index_q;
          end else if (!blocked_q) begin
            if (is_glob) begin
              req_o.glob_re      = 1'b1;
              stage_o.src        = sioc_pkg::SRC_GLOB;
              stage_o.imm        = sioc_pkg::glob_reset(gidx);
              stage_o.glob_valid = gvalid_q[gidx];
            end else if (dev_ok) begin
              req_o.bank_re = 1'b1;
              stage_o.src   = sioc_pkg::SRC_BANK;
            end
          end
        end
      end
    end

    stage_o.mode = mode_d == sioc_pkg::MODE_CONFIG;
  end

endmodule
`default_nettype wire

FILE: design/superio_config_space.sv
`default_nettype none
// Configuration port of a legacy I/O controller. Each transaction is one bus read or write
// to the index port or the data port, and each gives exactly one result transaction. A new
// transaction can be accepted in every cycle when no load pass runs and no back-pressure
// holds the output; its result goes through the stage register into the output register,
// as the register files are memories with a registered read. After reset a pass over every
// bank loads its default contents, during which no transaction is accepted.
module superio_config_space #(
  parameter int unsigned BANK_COUNT = sioc_pkg::BANK_COUNT_DEF
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       in_valid_i,
  output logic            in_ready_o,
  input  wire logic       op_i,
  input  wire logic       data_port_i,
  input  wire logic [7:0] write_data_i,
  output logic            out_valid_o,
  input  wire logic       out_ready_i,
  output logic [7:0]      read_data_o,
  output logic            in_config_mode_o
);

  localparam int unsigned BW    = $clog2(BANK_COUNT);
  localparam int unsigned DEPTH = BANK_COUNT * sioc_pkg::BANK_REGS;
  localparam int unsigned AW    = $clog2(DEPTH);

  sioc_pkg::init_t    init;
  sioc_pkg::mem_req_t req;
  sioc_pkg::stage_t   stage_d, stage_q;

  logic          accept;
  logic          s1_valid_q, s1_valid_d;
  logic          s1_adv;
  logic          out_valid_q;
  logic [7:0]    out_data_q;
  logic          out_mode_q;
  logic [7:0]    result;

  logic [BW-1:0] sel_bank;
  logic [7:0]    sel_offs;
  logic [AW-1:0] bank_addr;
  logic          bank_we;
  logic [7:0]    bank_wdata;
  logic [7:0]    bank_rdata;
  logic [7:0]    glob_rdata;

  sioc_init #(.BANK_COUNT(BANK_COUNT)) u_init (
    .clk_i,
    .rst_ni,
    .init_o(init)
  );

  sioc_decode #(.BANK_COUNT(BANK_COUNT)) u_decode (
    .clk_i,
    .rst_ni,
    .accept_i    (accept),
    .op_i,
    .data_port_i,
    .write_data_i,
    .req_o       (req),
    .stage_o     (stage_d)
  );

  assign sel_bank   = init.busy ? init.bank[BW-1:0] : req.bank_dev[BW-1:0];
  assign sel_offs   = init.busy ? init.offs : req.bank_offs;
  assign bank_addr  = AW'(AW'(sel_bank) * AW'(sioc_pkg::BANK_REGS)) + AW'(sel_offs);
  assign bank_we    = init.busy | req.bank_we;
  assign bank_wdata = init.busy ? init.wdata : req.wdata;

  sioc_ram #(.WIDTH(8), .DEPTH(DEPTH)) u_bank_ram (
    .clk_i,
    .we_i   (bank_we),
    .waddr_i(bank_addr),
    .wdata_i(bank_wdata),
    .re_i   (req.bank_re),
    .raddr_i(bank_addr),
    .rdata_o(bank_rdata)
  );

  sioc_ram #(.WIDTH(8), .DEPTH(sioc_pkg::GLOBAL_REGS)) u_glob_ram (
    .clk_i,
    .we_i   (req.glob_we),
    .waddr_i(req.glob_addr),
    .wdata_i(req.wdata),
    .re_i   (req.glob_re),
    .raddr_i(req.glob_addr),
    .rdata_o(glob_rdata)
  );

  assign s1_adv     = s1_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !init.busy && (!s1_valid_q || s1_adv);
  assign accept     = in_valid_i && in_ready_o;
  assign s1_valid_d = accept || (s1_valid_q && !s1_adv);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= s1_valid_d;
      if (s1_adv) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      stage_q <= stage_d;
    end
    if (s1_adv) begin
      out_data_q <= result;
      out_mode_q <= stage_q.mode;
    end
  end

  always_comb begin
    unique case (stage_q.src)
      sioc_pkg::SRC_GLOB: result = stage_q.glob_valid ? glob_rdata : stage_q.imm;
      sioc_pkg::SRC_BANK: result = bank_rdata;
      default:            result = stage_q.imm;
    endcase
  end

  assign out_valid_o      = out_valid_q;
  assign read_data_o      = out_data_q;
  assign in_config_mode_o = out_mode_q;

endmodule
`default_nettype wire

FILE: tb/sv/superio_config_space_tb.sv
`default_nettype none
module superio_config_space_tb;
  import sioc_pkg::*;

  localparam int unsigned BANK_COUNT      = BANK_COUNT_DEF;
  localparam int unsigned REG_SLOTS       = GLOBAL_REGS + BANK_COUNT * BANK_REGS;
  localparam int unsigned STALL_LIMIT     = 20000;
  localparam int unsigned ITEMS_PER_PHASE = 460;
  localparam int unsigned SETTLE_CYCLES   = 10;

  localparam logic OP_READ    = 1'b0;
  localparam logic OP_WRITE   = 1'b1;
  localparam logic PORT_INDEX = 1'b0;
  localparam logic PORT_DATA  = 1'b1;

  typedef struct packed {
    logic [7:0] read_data;
    logic       config_mode;
  } access_result_t;

  class config_port_scoreboard;
    logic           in_mode;
    logic           key_armed;
    logic [7:0]     cur_index;
    logic           data_locked;
    logic [7:0]     regs [REG_SLOTS];
    access_result_t expected_responses[$];
    int unsigned    errors;

    function new();
      in_mode     = 1'b0;
      key_armed   = 1'b0;
      cur_index   = 8'h00;
      data_locked = 1'b0;
      errors      = 0;
      foreach (regs[i]) regs[i] = 8'h00;
      regs[8'h20] = 8'h97;
      regs[8'h21] = 8'h71;
      regs[8'h22] = 8'hff;
      regs[8'h24] = 8'ha4;
      load_bank_defaults();
    endfunction

    function void set_default(int unsigned bank, int unsigned offs, logic [7:0] value);
      regs[GLOBAL_REGS + bank * BANK_REGS + offs] = value;
    endfunction

    function void load_bank_defaults();
      set_default(0, 'h00, 'h01); set_default(0, 'h01, 'h02); set_default(0, 'h30, 'h03);
      set_default(0, 'h31, 'hf0); set_default(0, 'h40, 'h06); set_default(0, 'h41, 'h02);
      set_default(0, 'h44, 'h02); set_default(0, 'hc0, 'h0e);
      set_default(1, 'h00, 'h01); set_default(1, 'h01, 'h02); set_default(1, 'h30, 'h03);
      set_default(1, 'h31, 'h78); set_default(1, 'h40, 'h07); set_default(1, 'h41, 'h01);
      set_default(1, 'h44, 'h04); set_default(1, 'hc0, 'h3c);
      set_default(2, 'h00, 'h01); set_default(2, 'h01, 'h02); set_default(2, 'h30, 'h03);
      set_default(2, 'h31, 'hf8); set_default(2, 'h40, 'h04); set_default(2, 'h41, 'h02);
      set_default(3, 'h00, 'h01); set_default(3, 'h01, 'h02); set_default(3, 'h30, 'h02);
      set_default(3, 'h31, 'hf8); set_default(3, 'h40, 'h03); set_default(3, 'h41, 'h02);
      set_default(4, 'h00, 'h01); set_default(4, 'h01, 'h02); set_default(4, 'h30, 'h00);
      set_default(4, 'h31, 'h70); set_default(4, 'h40, 'h08); set_default(4, 'h41, 'h02);
      set_default(5, 'h00, 'h01); set_default(5, 'h01, 'h02); set_default(5, 'h30, 'h00);
      set_default(5, 'h31, 'h60); set_default(5, 'h32, 'h00); set_default(5, 'h33, 'h64);
      set_default(5, 'h40, 'h01); set_default(5, 'h41, 'h02); set_default(5, 'h42, 'h0c);
      set_default(5, 'h43, 'h02); set_default(5, 'hc0, 'h40);
      set_default(6, 'h01, 'h02); set_default(6, 'h41, 'h02); set_default(6, 'h44, 'h04);
      set_default(6, 'h45, 'h04);
      set_default(7, 'h01, 'h02); set_default(7, 'h41, 'h02); set_default(7, 'h43, 'h02);
      set_default(7, 'hb0, 'h01); set_default(7, 'hb1, 'h01); set_default(7, 'hb2, 'h01);
      set_default(7, 'hb3, 'h01); set_default(7, 'hb4, 'h01); set_default(7, 'hb5, 'h01);
      set_default(7, 'hb6, 'h01);
      set_default(8, 'h01, 'h02); set_default(8, 'h41, 'h02); set_default(8, 'h43, 'h02);
      set_default(8, 'hb8, 'h01); set_default(8, 'hb9, 'h01); set_default(8, 'hba, 'h01);
      set_default(8, 'hbb, 'h01); set_default(8, 'hbc, 'h01); set_default(8, 'hbd, 'h01);
      set_default(8, 'hbe, 'h01); set_default(8, 'hbf, 'h01);
    endfunction

    // Flat slot of the register that the current index reaches, or -1 when the
    // logical device number lies beyond the implemented banks.
    function int selected_slot();
      int unsigned dev;
      if (cur_index < BANK_BASE) return int'(cur_index);
      dev = regs[DEV_SEL_REG];
      if (dev >= BANK_COUNT) return -1;
      return GLOBAL_REGS + dev * BANK_REGS + (cur_index - BANK_BASE);
    endfunction

    function access_result_t predict_access(logic op, logic port, logic [7:0] value);
      access_result_t res;
      int             slot;
      res.read_data = 8'h00;
      slot = selected_slot();
      if (op == OP_WRITE) begin
        if (port == PORT_INDEX) begin
          if (!in_mode && value == KEY_ENTER) begin
            if (key_armed) begin
              in_mode   = 1'b1;
              key_armed = 1'b0;
            end else begin
              key_armed = 1'b1;
            end
          end else if (in_mode) begin
            if (value == KEY_EXIT) in_mode = 1'b0;
            else cur_index = value;
          end else begin
            key_armed = 1'b0;
          end
        end else if (in_mode && !data_locked && slot >= 0) begin
          regs[slot] = value;
          if (cur_index == LOCK_REG) data_locked = value[LOCK_BIT];
        end
      end else begin
        res.read_data = IDLE_READ;
        if (in_mode) begin
          if (port == PORT_INDEX) res.read_data = cur_index;
          else if (!data_locked && slot >= 0) res.read_data = regs[slot];
        end
      end
      res.config_mode = in_mode;
      return res;
    endfunction

    function void note_access(logic op, logic port, logic [7:0] value);
      expected_responses.push_back(predict_access(op, port, value));
    endfunction

    function int unsigned pending();
      return expected_responses.size();
    endfunction

    task report(string msg);
      $display("MISMATCH at %0t: %s", $realtime, msg);
      errors++;
    endtask

    task check_result(logic [7:0] read_data, logic config_mode);
      access_result_t exp;
      if (expected_responses.size() == 0) begin
        report($sformatf("result with nothing outstanding: read_data=%02h mode=%0b",
                         read_data, config_mode));
      end else begin
        exp = expected_responses.pop_front();
        if (read_data !== exp.read_data)
          report($sformatf("read_data %02h, expected %02h", read_data, exp.read_data));
        if (config_mode !== exp.config_mode)
          report($sformatf("in_config_mode %0b, expected %0b", config_mode,
                           exp.config_mode));
      end
    endtask
  endclass

  logic       clk_i          = 1'b0;
  logic       rst_ni         = 1'b0;
  logic       in_valid_i     = 1'b0;
  logic       op_i           = OP_READ;
  logic       data_port_i    = PORT_INDEX;
  logic [7:0] write_data_i   = 8'h00;
  logic       out_ready_i    = 1'b0;
  logic       in_ready_o;
  logic       out_valid_o;
  logic [7:0] read_data_o;
  logic       in_config_mode_o;

  config_port_scoreboard sb = new();
  int unsigned send_idle_pct  = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned accesses_sent  = 0;
  int unsigned stalled_cycles = 0;
  logic        lock_allowed   = 1'b0;

  superio_config_space #(.BANK_COUNT(BANK_COUNT)) dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .op_i            (op_i),
    .data_port_i     (data_port_i),
    .write_data_i    (write_data_i),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .read_data_o     (read_data_o),
    .in_config_mode_o(in_config_mode_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    out_ready_i <= ($urandom_range(0, 99) >= recv_stall_pct);
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) sb.check_result(read_data_o, in_config_mode_o);
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      stalled_cycles <= 0;
    end else if (stalled_cycles >= STALL_LIMIT) begin
      $display("superio_config_space_tb failed");
      $finish;
    end else begin
      stalled_cycles <= stalled_cycles + 1;
    end
  end

  task automatic send_access(logic op, logic port, logic [7:0] value);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    // The lock bit may only be set in the final phase, as only reset clears it.
    if (op == OP_WRITE && port == PORT_DATA && sb.in_mode && sb.cur_index == LOCK_REG &&
        !lock_allowed)
      value[LOCK_BIT] = 1'b0;
    in_valid_i   <= 1'b1;
    op_i         <= op;
    data_port_i  <= port;
    write_data_i <= value;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    sb.note_access(op, port, value);
    accesses_sent++;
  endtask

  task automatic write_index(logic [7:0] value);
    send_access(OP_WRITE, PORT_INDEX, value);
  endtask

  task automatic write_data(logic [7:0] value);
    send_access(OP_WRITE, PORT_DATA, value);
  endtask

  task automatic read_index();
    send_access(OP_READ, PORT_INDEX, 8'($urandom_range(0, 255)));
  endtask

  task automatic read_data_port();
    send_access(OP_READ, PORT_DATA, 8'($urandom_range(0, 255)));
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (sb.pending() != 0) @(posedge clk_i);
  endtask

  function automatic logic [7:0] pick_index();
    logic [7:0] idx;
    if ($urandom_range(0, 99) < 40) idx = 8'($urandom_range(0, BANK_BASE - 1));
    else idx = 8'($urandom_range(BANK_BASE, 255));
    if (idx == KEY_EXIT) idx = KEY_EXIT + 8'd1;
    return idx;
  endfunction

  function automatic logic [7:0] pick_device();
    if ($urandom_range(0, 99) < 85) return 8'($urandom_range(0, BANK_COUNT - 1));
    return 8'($urandom_range(0, 255));
  endfunction

  task automatic config_session();
    int unsigned pick;
    if (!sb.in_mode || $urandom_range(0, 3) == 0) begin
      write_index(KEY_ENTER);
      write_index(KEY_ENTER);
    end
    repeat ($urandom_range(3, 14)) begin
      pick = $urandom_range(0, 99);
      if (pick < 20) begin
        write_index(DEV_SEL_REG);
        write_data(pick_device());
      end else if (pick < 45) begin
        write_index(pick_index());
      end else if (pick < 70) begin
        write_data(8'($urandom_range(0, 255)));
      end else if (pick < 92) begin
        read_data_port();
      end else begin
        read_index();
      end
    end
    if ($urandom_range(0, 99) < 80) write_index(KEY_EXIT);
  endtask

  task automatic bus_noise();
    logic [7:0] value;
    repeat ($urandom_range(1, 6)) begin
      value = ($urandom_range(0, 2) == 0) ? KEY_ENTER : 8'($urandom_range(0, 255));
      send_access(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)), value);
    end
  endtask

  task automatic run_random(int unsigned count);
    int unsigned first;
    first = accesses_sent;
    while (accesses_sent - first < count) begin
      if ($urandom_range(0, 99) < 85) config_session();
      else bus_noise();
    end
  endtask

  initial begin
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    read_data_port();
    read_index();
    write_data(8'hff);
    write_index(8'h00);
    write_index(KEY_ENTER);
    write_index(8'h12);
    write_index(KEY_ENTER);
    write_index(KEY_ENTER);
    read_index();
    write_index(8'h20);
    read_data_port();
    write_index(KEY_ENTER);
    read_data_port();
    write_index(DEV_SEL_REG);
    write_data(8'hff);
    write_index(BANK_BASE);
    write_data(8'h55);
    read_data_port();
    write_index(DEV_SEL_REG);
    write_data(8'h00);
    write_index(8'hff);
    write_data(8'hff);
    read_data_port();
    write_index(KEY_EXIT);
    read_index();
    drain();

    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin
          send_idle_pct  = 0;
          recv_stall_pct = 0;
        end
        1: begin
          send_idle_pct  = 52;
          recv_stall_pct = 0;
        end
        2: begin
          send_idle_pct  = 0;
          recv_stall_pct = 52;
        end
        default: begin
          send_idle_pct  = 21;
          recv_stall_pct = 21;
        end
      endcase
      run_random(ITEMS_PER_PHASE);
      drain();
    end

    // Once the lock bit is set, every data access stays blocked until reset.
    lock_allowed = 1'b1;
    if (!sb.in_mode) begin
      write_index(KEY_ENTER);
      write_index(KEY_ENTER);
    end
    write_index(LOCK_REG);
    write_data(8'h20 | 8'($urandom_range(0, 255)));
    repeat (30) begin
      case ($urandom_range(0, 3))
        0: write_index(pick_index());
        1: write_data(8'($urandom_range(0, 255)));
        2: read_index();
        default: read_data_port();
      endcase
    end
    write_index(KEY_EXIT);
    read_data_port();
    write_index(KEY_ENTER);
    write_index(KEY_ENTER);
    read_data_port();
    write_index(KEY_EXIT);

    drain();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (sb.errors == 0) begin
      $display("superio_config_space_tb passed");
    end else begin
      $display("superio_config_space_tb failed");
    end
    $finish;
  end

endmodule
`default_nettype wire

FILE: sim.f
design/sioc_pkg.sv
design/sioc_ram.sv
design/sioc_init.sv
design/sioc_decode.sv
design/superio_config_space.sv
tb/sv/superio_config_space_tb.sv
